@@ rtl/core/lps_pkg.sv @@
`default_nettype none

package lps_pkg;

  // Store geometry.
  localparam int MAX_ELEMENTS  = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ADDR_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W         = $clog2(MAX_ELEMENTS + 1);

  // Stream field widths.
  localparam int IN_VALUE_W   = 32;
  localparam int RUN_START_W  = 6;
  localparam int RUN_LENGTH_W = 7;
  localparam int OUT_DATA_W   = 16;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_e;

  // Requests from the sequencer to the element store.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
  } store_req_t;

  // Finished search result handed to the output register.
  typedef struct packed {
    logic             valid;
    logic [ADDR_W-1:0] start;
    logic [CNT_W-1:0]  length;
    logic             truncated;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/longest_palindrome_subarray.sv @@
// Loading takes one element per cycle; after the final element the search tries runs from
// longest to shortest, lowest start first: it sets up each candidate, then reads and compares
// each pair through the shared store. Throughput: one sequence at a time; a result may wait
// in the output register while the next sequence loads. Reset clears the sequencer, count,
// flag and output valid asynchronously; the store is not cleared.
`default_nettype none

module longest_palindrome_subarray (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] element_value
  input  wire  [lps_pkg::IN_VALUE_W-1:0]     s_axis_tdata,
  // is_final
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [5:0] run_start, [12:6] run_length, [15:13] zero
  output logic [lps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] truncated
  output logic                               m_axis_tuser
);

  lps_pkg::store_req_t                 req;
  lps_pkg::result_t                    res;
  logic [lps_pkg::ELEMENT_WIDTH-1:0]   rd_data_a;
  logic [lps_pkg::ELEMENT_WIDTH-1:0]   rd_data_b;
  logic [lps_pkg::ELEMENT_WIDTH-1:0]   wr_data;

  logic                                out_valid_q;
  logic [lps_pkg::RUN_START_W-1:0]     out_start_q;
  logic [lps_pkg::RUN_LENGTH_W-1:0]    out_length_q;
  logic                                out_trunc_q;

  assign wr_data = lps_pkg::ELEMENT_WIDTH'(s_axis_tdata);

  lps_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .wr_data_i   (wr_data),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  lps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .res_ready_i (!out_valid_q),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .req_o       (req),
    .res_o       (res)
  );

  // Output valid: set by a finished search, cleared when the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_start_q  <= lps_pkg::RUN_START_W'(res.start);
      out_length_q <= lps_pkg::RUN_LENGTH_W'(res.length);
      out_trunc_q  <= res.truncated;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = lps_pkg::OUT_DATA_W'({out_length_q, out_start_q});
  assign m_axis_tuser  = out_trunc_q;

endmodule

`default_nettype wire

@@ rtl/core/lps_store.sv @@
`default_nettype none

module lps_store (
  input  wire                                  clk_i,
  input  lps_pkg::store_req_t                  req_i,
  input  wire  [lps_pkg::ELEMENT_WIDTH-1:0]    wr_data_i,
  output logic [lps_pkg::ELEMENT_WIDTH-1:0]    rd_data_a_o,
  output logic [lps_pkg::ELEMENT_WIDTH-1:0]    rd_data_b_o
);

  logic [lps_pkg::ELEMENT_WIDTH-1:0] mem [lps_pkg::MAX_ELEMENTS];

  // One write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data_i;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_a_o <= mem[req_i.rd_addr_a];
      rd_data_b_o <= mem[req_i.rd_addr_b];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lps_ctrl.sv @@
`default_nettype none

module lps_ctrl (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  input  wire                                  in_last_i,
  output logic                                 in_ready_o,
  input  wire                                  res_ready_i,
  input  wire  [lps_pkg::ELEMENT_WIDTH-1:0]    rd_data_a_i,
  input  wire  [lps_pkg::ELEMENT_WIDTH-1:0]    rd_data_b_i,
  output lps_pkg::store_req_t                  req_o,
  output lps_pkg::result_t                     res_o
);

  lps_pkg::state_e state_q, state_d;

  logic [lps_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  logic [lps_pkg::CNT_W-1:0]  len_q, len_d;
  logic [lps_pkg::ADDR_W-1:0] start_q, start_d;
  logic [lps_pkg::ADDR_W-1:0] lo_q, lo_d;
  logic [lps_pkg::ADDR_W-1:0] hi_q, hi_d;

  logic                       in_fire;
  logic                       store_full;
  logic                       pair_equal;
  logic                       run_closed;
  logic [lps_pkg::CNT_W:0]    span_end;
  logic [lps_pkg::CNT_W:0]    last_idx;

  assign in_ready_o = (state_q == lps_pkg::ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign store_full = (cnt_q == lps_pkg::CNT_W'(lps_pkg::MAX_ELEMENTS));
  assign pair_equal = (rd_data_a_i == rd_data_b_i);
  assign run_closed = (lo_q >= hi_q);

  // End of the candidate run (exclusive) and its last index.
  assign span_end = {1'b0, (lps_pkg::CNT_W)'(start_q)} + {1'b0, len_q};
  assign last_idx = span_end - 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lps_pkg::ST_LOAD: begin
        if (in_fire && in_last_i) begin
          state_d = lps_pkg::ST_INIT;
        end
      end
      lps_pkg::ST_INIT: begin
        state_d = lps_pkg::ST_READ;
      end
      lps_pkg::ST_READ: begin
        state_d = run_closed ? lps_pkg::ST_DONE : lps_pkg::ST_CMP;
      end
      lps_pkg::ST_CMP: begin
        state_d = pair_equal ? lps_pkg::ST_READ : lps_pkg::ST_INIT;
      end
      lps_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = lps_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = lps_pkg::ST_LOAD;
      end
    endcase
  end

  // Datapath updates and outputs.
  always_comb begin
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    len_d   = len_q;
    start_d = start_q;
    lo_d    = lo_q;
    hi_d    = hi_q;

    req_o.wr_en     = 1'b0;
    req_o.wr_addr   = cnt_q[lps_pkg::ADDR_W-1:0];
    req_o.rd_en     = 1'b0;
    req_o.rd_addr_a = lo_q;
    req_o.rd_addr_b = hi_q;

    res_o.valid     = 1'b0;
    res_o.start     = start_q;
    res_o.length    = len_q;
    res_o.truncated = ovf_q;

    case (state_q)
      lps_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            req_o.wr_en = 1'b1;
            cnt_d       = cnt_q + 1'b1;
          end
          // Search starts with the whole sequence as the first candidate.
          len_d   = store_full ? cnt_q : cnt_q + 1'b1;
          start_d = '0;
        end
      end
      lps_pkg::ST_INIT: begin
        lo_d = start_q;
        hi_d = last_idx[lps_pkg::ADDR_W-1:0];
      end
      lps_pkg::ST_READ: begin
        req_o.rd_en = !run_closed;
      end
      lps_pkg::ST_CMP: begin
        if (pair_equal) begin
          lo_d = lo_q + 1'b1;
          hi_d = hi_q - 1'b1;
        end else if (span_end < {1'b0, cnt_q}) begin
          // Slide the window one place to the right.
          start_d = start_q + 1'b1;
        end else begin
          // Shorten the window and restart from the left.
          len_d   = len_q - 1'b1;
          start_d = '0;
        end
      end
      lps_pkg::ST_DONE: begin
        if (res_ready_i) begin
          res_o.valid = 1'b1;
          cnt_d       = '0;
          ovf_d       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lps_pkg::ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  // Search registers.
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    start_q <= start_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
  end

  // A compare always follows the read that fetched its pair.
  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lps_pkg::ST_CMP |-> $past(state_q) == lps_pkg::ST_READ)
    else $error("compare without a preceding read");

  // Reads never go beyond the loaded elements.
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.rd_en |-> ({1'b0, hi_q} < {1'b0, cnt_q}) && (lo_q < hi_q))
    else $error("store read outside the loaded sequence");

  // A reported run is never empty.
  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> len_q != '0)
    else $error("empty run reported");

  // The element count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lps_pkg::ST_LOAD && $past(state_q) == lps_pkg::ST_LOAD
    |-> cnt_q <= lps_pkg::CNT_W'(lps_pkg::MAX_ELEMENTS))
    else $error("element count overflow");

endmodule

`default_nettype wire

@@ verif/tb_longest_palindrome_subarray.sv @@
`timescale 1ns / 100ps

module tb_longest_palindrome_subarray;

  // No transaction for this many cycles means the block is hung.
  localparam int WATCHDOG_LIMIT = 200_000;
  localparam int NUM_PHASES     = 4;
  localparam int PHASE_ITEMS    = 90;

  // One expected search result.
  typedef struct {
    logic [lps_pkg::RUN_START_W-1:0]  start;
    logic [lps_pkg::RUN_LENGTH_W-1:0] length;
    logic                             truncated;
  } run_result_t;

  // Tracks the loaded sequence, predicts the longest mirrored run and checks results.
  class run_scoreboard;
    logic [lps_pkg::ELEMENT_WIDTH-1:0] elems [lps_pkg::MAX_ELEMENTS];
    int unsigned                       count;
    logic                              dropped;
    run_result_t                       expected_runs [$];
    int unsigned                       mismatches;

    function new();
      count      = 0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function bit is_mirror(int lo, int hi);
      while (lo < hi) begin
        if (elems[lo] != elems[hi]) return 1'b0;
        lo++;
        hi--;
      end
      return 1'b1;
    endfunction

    // Longest length first, lowest start first, so the first hit wins.
    function void find_longest(output int unsigned start, output int unsigned length);
      start  = 0;
      length = 0;
      for (int len = count; len >= 1; len--) begin
        for (int s = 0; s + len <= count; s++) begin
          if (is_mirror(s, s + len - 1)) begin
            start  = s;
            length = len;
            return;
          end
        end
      end
    endfunction

    // Called for every accepted input transaction.
    function void note_element(logic [lps_pkg::ELEMENT_WIDTH-1:0] value, logic fin);
      int unsigned start, length;
      run_result_t res;
      if (count < lps_pkg::MAX_ELEMENTS) begin
        elems[count] = value;
        count++;
      end else begin
        dropped = 1'b1;
      end
      if (fin) begin
        find_longest(start, length);
        res.start     = start[lps_pkg::RUN_START_W-1:0];
        res.length    = length[lps_pkg::RUN_LENGTH_W-1:0];
        res.truncated = dropped;
        expected_runs.push_back(res);
        count   = 0;
        dropped = 1'b0;
      end
    endfunction

    // Called for every accepted output transaction.
    task check_run(logic [lps_pkg::OUT_DATA_W-1:0] data, logic user);
      run_result_t exp;
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h user=%b", data, user));
        return;
      end
      exp = expected_runs.pop_front();
      if (data[lps_pkg::RUN_START_W-1:0] !== exp.start)
        report_mismatch($sformatf("run_start %0d, expected %0d",
                                  data[lps_pkg::RUN_START_W-1:0], exp.start));
      if (data[lps_pkg::RUN_START_W +: lps_pkg::RUN_LENGTH_W] !== exp.length)
        report_mismatch($sformatf("run_length %0d, expected %0d",
                                  data[lps_pkg::RUN_START_W +: lps_pkg::RUN_LENGTH_W],
                                  exp.length));
      if (data[lps_pkg::OUT_DATA_W-1:lps_pkg::RUN_START_W+lps_pkg::RUN_LENGTH_W] !== '0)
        report_mismatch($sformatf("padding bits not zero, data=%h", data));
      if (user !== exp.truncated)
        report_mismatch($sformatf("truncated %b, expected %b", user, exp.truncated));
    endtask
  endclass

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [lps_pkg::IN_VALUE_W-1:0]    s_axis_tdata  = '0;
  logic                              s_axis_tlast  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [lps_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
  logic                              m_axis_tuser;

  run_scoreboard                     sb;
  logic [lps_pkg::IN_VALUE_W-1:0]    seq_buf [$];
  int unsigned                       idle_pct;
  int unsigned                       stall_pct;
  int unsigned                       elements_sent;
  int unsigned                       quiet_cycles;

  longest_palindrome_subarray dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Drive one element, with random idle cycles before it, and wait for the transaction.
  task automatic send_element(logic [lps_pkg::IN_VALUE_W-1:0] value, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_element(value, fin);
    elements_sent++;
  endtask

  // Send the buffered sequence, marking its final element.
  task automatic send_seq_buf();
    foreach (seq_buf[i]) send_element(seq_buf[i], i == seq_buf.size() - 1);
    seq_buf.delete();
  endtask

  // Build a random sequence, mostly short and mostly from a small value pool, so runs mirror often.
  task automatic build_random_seq();
    int unsigned                       len;
    int unsigned                       mode;
    int unsigned                       run_len;
    int unsigned                       offs;
    logic [lps_pkg::IN_VALUE_W-1:0]    pool [3];
    seq_buf.delete();
    len     = ($urandom_range(15) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
    pool[0] = $urandom;
    // A value one bit away from the first catches partial-width compares.
    pool[1] = pool[0] ^ (32'h1 << $urandom_range(31));
    pool[2] = $urandom;
    mode    = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      if (mode < 2) seq_buf.push_back($urandom);
      else seq_buf.push_back(pool[$urandom_range((mode < 6) ? 1 : 2)]);
    end
    // In some modes, plant a mirrored stretch at a random place.
    if ((mode == 0 || mode >= 6) && len > 1) begin
      run_len = $urandom_range(2, len);
      offs    = $urandom_range(0, len - run_len);
      for (int i = 0; i < run_len / 2; i++) seq_buf[offs + run_len - 1 - i] = seq_buf[offs + i];
    end
  endtask

  // Result side: check each transaction and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_run(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("longest_palindrome_subarray test failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_idle  [NUM_PHASES];
    int unsigned phase_stall [NUM_PHASES];
    int unsigned phase_end;
    logic [lps_pkg::IN_VALUE_W-1:0] v;

    phase_idle    = '{0, 76, 0, 18};
    phase_stall   = '{0, 0, 76, 18};
    sb            = new();
    idle_pct      = 0;
    stall_pct     = 0;
    elements_sent = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single element at the most negative value.
    seq_buf = '{32'h8000_0000};
    send_seq_buf();
    // Odd mirror around the all-ones value.
    seq_buf = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
    send_seq_buf();
    // All distinct: the first single element wins.
    seq_buf = '{32'h0000_0000, 32'h0000_0001};
    send_seq_buf();
    // Even mirror over the whole sequence.
    seq_buf = '{32'h0000_0007, 32'h8000_0003, 32'h8000_0003, 32'h0000_0007};
    send_seq_buf();
    // Two runs of equal length: the lower start wins.
    seq_buf = '{32'h9, 32'h1, 32'h2, 32'h1, 32'h5, 32'h4, 32'h5};
    send_seq_buf();

    // Store exactly full with one mirror across all of it.
    for (int i = 0; i < lps_pkg::MAX_ELEMENTS / 2; i++) seq_buf.push_back($urandom);
    for (int i = lps_pkg::MAX_ELEMENTS / 2 - 1; i >= 0; i--) seq_buf.push_back(seq_buf[i]);
    send_seq_buf();

    // Store overflows; the final element is dropped but still closes the sequence.
    for (int i = 0; i < lps_pkg::MAX_ELEMENTS + 2; i++) seq_buf.push_back($urandom);
    for (int i = 0; i < 2; i++) seq_buf[44 - i] = seq_buf[40 + i];
    send_seq_buf();

    // Random sequences under each idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      phase_end = elements_sent + PHASE_ITEMS;
      while (elements_sent < phase_end) begin
        build_random_seq();
        send_seq_buf();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray ones.
    while (sb.expected_runs.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_runs.size() == 0) begin
      $display("longest_palindrome_subarray test passed");
    end else begin
      $display("longest_palindrome_subarray test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lps_pkg.sv
rtl/core/lps_store.sv
rtl/core/lps_ctrl.sv
rtl/core/longest_palindrome_subarray.sv
verif/tb_longest_palindrome_subarray.sv
